/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/elp_pkg.sv */
package elp_pkg;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned LabelWidth = 6;
   localparam int unsigned CfgWidth   = 31;
   localparam int unsigned SumWidth   = 40;
   localparam int unsigned ScaleOne   = 65536;

   // Register indexes of the configuration port.
   localparam logic CSR_LAMBDA    = 1'b0;
   localparam logic CSR_TOLERANCE = 1'b1;

   // One element record as held in the element memory.
   typedef struct packed {
      logic signed [ValueWidth-1:0] value;
      logic [LabelWidth-1:0]        label;
      logic signed [ValueWidth-1:0] lower;
      logic signed [ValueWidth-1:0] upper;
   } elem_type;

   localparam int unsigned ElemWidth = $bits(elem_type);

   // Start and status between sequencer and update unit.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } upd_ctl_type;

endpackage

/* sv/elp_ram.sv */
module elp_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/elp_div.sv */
// Restoring divider, one quotient bit per cycle: quo = num / den, unsigned.
module elp_div
   import elp_pkg::*;
#(
   parameter int unsigned NW = 49,
   parameter int unsigned DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quo
);

   localparam int unsigned CW = $clog2(NW + 1);

   logic [NW-1:0] quo_ff, quo_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [DW+1:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = '0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quo_ff[NW-1]} - {2'b00, den_ff};
         if (!trial[DW+1]) begin
            rem_in = trial[DW:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DW-1:0], quo_ff[NW-1]};
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

/* sv/elp_upd.sv */
// One coordinate update: threshold, soft threshold, scale, clamp, change.
module elp_upd
   import elp_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  upd_ctl_type                  ctl_i,
   input  logic [CfgWidth-1:0]          lambda,
   input  logic [SumWidth-1:0]          abs_sum,
   input  elem_type                     elem,
   input  logic signed [ValueWidth-1:0] beta_old,
   output upd_ctl_type                  ctl_o,
   output logic signed [ValueWidth-1:0] beta_new,
   output logic [63:0]                  change_sq
);

   typedef enum logic [6:0] {
      U_IDLE = 7'b0000001,
      U_MLO  = 7'b0000010,
      U_MHI  = 7'b0000100,
      U_SOFT = 7'b0001000,
      U_DIV  = 7'b0010000,
      U_WAIT = 7'b0100000,
      U_DONE = 7'b1000000
   } ustate_type;

   ustate_type               st_ff, st_in;
   logic [SumWidth-1:0]      level_ff, level_in;
   logic [62:0]              plo_ff, plo_in;
   logic [32:0]              thr_ff, thr_in;
   logic signed [33:0]       r_ff, r_in;
   logic signed [ValueWidth-1:0] nb_ff, nb_in;
   logic [63:0]              sq_ff, sq_in;
   logic [38:0]              phi;
   logic [70:0]              prod;
   logic [54:0]              thr_raw;
   logic [33:0]              mag_r;
   logic [48:0]              div_num;
   logic [48:0]              div_quo;
   logic                     div_busy;
   logic                     div_start;
   logic signed [34:0]       q_s;
   logic signed [34:0]       cl;
   logic signed [33:0]       d;
   logic [32:0]              ad;
   logic [32:0]              abs_old;
   logic signed [34:0]       zx;

   // Threshold product: lambda times (group L1 minus own magnitude), taken in two
   // steps. The low 32 bits of the level are multiplied first, then the top byte
   // is added in and the result is brought back to Q16.16 and capped at 2^32.
   assign phi     = {8'd0, lambda} * {31'd0, level_ff[39:32]};
   assign prod    = {phi, 32'd0} + {8'd0, plo_ff};
   assign thr_raw = prod[70:16];
   assign zx      = 35'(elem.value);
   assign mag_r   = r_ff[33] ? 34'(-r_ff) : r_ff;
   assign div_num = {mag_r[32:0], 16'd0};
   assign div_start = (st_ff == U_DIV);
   assign abs_old = beta_old[31] ? 33'(-34'(beta_old)) : {1'b0, beta_old};

   elp_div #(.NW(49), .DW(32)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (32'(ScaleOne) + {1'b0, lambda}),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   always_comb begin
      st_in    = st_ff;
      level_in = level_ff;
      plo_in   = plo_ff;
      thr_in   = thr_ff;
      r_in     = r_ff;
      nb_in    = nb_ff;
      sq_in    = sq_ff;
      q_s      = '0;
      cl       = '0;
      d        = '0;
      ad       = '0;
      unique case (st_ff)
         U_IDLE: begin
            if (ctl_i.start) begin
               level_in = abs_sum - SumWidth'(abs_old);
               st_in    = U_MLO;
            end
         end
         U_MLO: begin
            plo_in = {32'd0, lambda} * {31'd0, level_ff[31:0]};
            st_in  = U_MHI;
         end
         U_MHI: begin
            thr_in = (thr_raw >= 55'h1_0000_0000) ? 33'h1_0000_0000 : thr_raw[32:0];
            st_in  = U_SOFT;
         end
         U_SOFT: begin
            if (zx > $signed({2'b00, thr_ff})) begin
               r_in = 34'(zx - $signed({2'b00, thr_ff}));
            end else if (zx < -$signed({2'b00, thr_ff})) begin
               r_in = 34'(zx + $signed({2'b00, thr_ff}));
            end else begin
               r_in = '0;
            end
            st_in = U_DIV;
         end
         U_DIV: begin
            st_in = U_WAIT;
         end
         U_WAIT: begin
            if (!div_busy) begin
               q_s = r_ff[33] ? -$signed({1'b0, div_quo[33:0]}) : $signed({1'b0, div_quo[33:0]});
               cl  = q_s;
               if (cl < 35'(elem.lower)) cl = 35'(elem.lower);
               if (cl > 35'(elem.upper)) cl = 35'(elem.upper);
               nb_in = cl[31:0];
               d     = 34'(cl) - 34'(beta_old);
               ad    = d[33] ? 33'(-d) : d[32:0];
               sq_in = 64'({31'd0, ad} * {31'd0, ad});
               st_in = U_DONE;
            end
         end
         U_DONE: begin
            st_in = U_IDLE;
         end
         default: st_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= U_IDLE;
      end else begin
         st_ff <= st_in;
      end
      level_ff <= level_in;
      plo_ff   <= plo_in;
      thr_ff   <= thr_in;
      r_ff     <= r_in;
      nb_ff    <= nb_in;
      sq_ff    <= sq_in;
   end

   assign ctl_o.start = 1'b0;
   assign ctl_o.busy  = (st_ff != U_IDLE);
   assign ctl_o.done  = (st_ff == U_DONE);
   assign beta_new    = nb_ff;
   assign change_sq   = sq_ff;

endmodule

/* sv/exclusive_lasso_prox_engine_core.sv */
// Exclusive lasso proximal engine. Requests (value, group label, bounds) are
// loaded one per cycle into an element memory; the request marked last starts
// the solve, even when it finds the memory full and is not stored itself.
// Groups are solved in label order by coordinate passes: each element is read
// from the element and coefficient memories, updated by a shared update unit
// (a two-step threshold multiply, soft threshold, a serial restoring divide
// for the 1/(1+lambda) scaling, clamp and squared change) and written back.
// A member update waits on the serial divider; an element of another group
// is only read and skipped. Every group, empty or not, is initialized by a
// scan over all elements, and each pass it runs scans all elements and updates
// its members, so the solve time is set by the group sizes and by how many
// passes each group needs. Results then leave in input order through an
// output register, which holds a result while the response is stalled. The
// block accepts no request from the last request until the last result of
// that run has been taken.
module exclusive_lasso_prox_engine_core
   import elp_pkg::*;
#(
   parameter int unsigned MAX_ELEMENTS = 64,
   parameter int unsigned MAX_GROUPS   = 64,
   parameter int unsigned MAX_PASSES   = 100
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [ValueWidth-1:0] req_value_in,
   input  logic [LabelWidth-1:0]        req_group_label,
   input  logic signed [ValueWidth-1:0] req_lower_limit,
   input  logic signed [ValueWidth-1:0] req_upper_limit,
   input  logic                         req_last_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [ValueWidth-1:0] rsp_beta_out,
   output logic                         rsp_no_convergence,
   output logic                         rsp_last_out,
   input  logic                         csr_write,
   input  logic                         csr_index,
   input  logic [CfgWidth-1:0]          csr_data
);

   localparam int unsigned AW = $clog2(MAX_ELEMENTS);
   localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
   localparam int unsigned GW = $clog2(MAX_GROUPS + 1);
   localparam int unsigned PW = $clog2(MAX_PASSES + 1);

   // Sequencer states.
   typedef enum logic [8:0] {
      S_LOAD  = 9'b000000001,
      S_INITR = 9'b000000010,  // issue read for group init scan
      S_INITW = 9'b000000100,  // data back: init beta and L1
      S_PASSR = 9'b000001000,  // issue read for pass scan
      S_PASSD = 9'b000010000,  // data back, decide membership
      S_UPD   = 9'b000100000,  // update unit at work
      S_CHECK = 9'b001000000,  // convergence test after a pass
      S_OUTR  = 9'b010000000,  // issue read for output, wait for output register
      S_OUTW  = 9'b100000000   // data back: load output register
   } state_type;

   state_type              st_ff, st_in;
   logic [CfgWidth-1:0]    lambda_ff, tol_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [GW-1:0]          grp_ff, grp_in;
   logic [PW-1:0]          pass_ff, pass_in;
   logic [SumWidth-1:0]    sum_ff, sum_in;
   logic [63:0]            chg_ff, chg_in;
   logic                   any_ff, any_in;
   logic                   flag_ff, flag_in;
   logic                   out_v_ff, out_v_in;
   logic signed [ValueWidth-1:0] out_b_ff, out_b_in;
   logic                   out_l_ff, out_l_in;

   elem_type               wr_elem, rd_elem;
   logic                   e_we, b_we;
   logic [AW-1:0]          e_waddr, b_waddr, rd_addr;
   logic signed [ValueWidth-1:0] b_wdata, b_rdata;
   upd_ctl_type            uctl_i, uctl_o;
   logic signed [ValueWidth-1:0] u_beta;
   logic [63:0]            u_sq;
   logic [GW-1:0]          lab_eff;
   logic                   member;
   logic                   accept;
   logic [32:0]            mag_v, mag_nb, mag_ob;
   logic [64:0]            chg_sum;
   logic [61:0]            tol2;

   // Loading waits until the last result of the previous run has left the output
   // register, so the convergence flag it shows cannot change under it.
   assign accept = req_valid && !req_stall;
   assign req_stall = (st_ff != S_LOAD) || out_v_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         lambda_ff <= CfgWidth'(ScaleOne);
         tol_ff    <= CfgWidth'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LAMBDA:    lambda_ff <= csr_data;
            CSR_TOLERANCE: tol_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   assign wr_elem = '{value: req_value_in, label: req_group_label,
                      lower: req_lower_limit, upper: req_upper_limit};
   assign e_we    = accept && (count_ff < CW'(MAX_ELEMENTS));
   assign e_waddr = count_ff[AW-1:0];
   assign rd_addr = idx_ff[AW-1:0];

   elp_ram #(.WIDTH(ElemWidth), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
      .clock (clock), .wr_en (e_we), .wr_addr (e_waddr), .wr_data (wr_elem),
      .rd_addr (rd_addr), .rd_data (rd_elem)
   );

   elp_ram #(.WIDTH(ValueWidth), .DEPTH(MAX_ELEMENTS)) u_beta_ram (
      .clock (clock), .wr_en (b_we), .wr_addr (b_waddr), .wr_data (b_wdata),
      .rd_addr (rd_addr), .rd_data (b_rdata)
   );

   elp_upd u_upd (
      .clock (clock), .reset (reset), .ctl_i (uctl_i), .lambda (lambda_ff),
      .abs_sum (sum_ff), .elem (rd_elem), .beta_old (b_rdata),
      .ctl_o (uctl_o), .beta_new (u_beta), .change_sq (u_sq)
   );

   // Labels at or above the group count fold into the top group.
   always_comb begin
      if ({{(GW > LabelWidth ? GW - LabelWidth : 1){1'b0}}, rd_elem.label} >=
          (GW > LabelWidth ? GW : LabelWidth + 1)'(MAX_GROUPS)) begin
         lab_eff = GW'(MAX_GROUPS - 1);
      end else begin
         lab_eff = GW'(rd_elem.label);
      end
   end
   assign member = (lab_eff == grp_ff);

   assign mag_v  = rd_elem.value[31] ? 33'(-34'(rd_elem.value)) : {1'b0, rd_elem.value};
   assign mag_nb = u_beta[31] ? 33'(-34'(u_beta)) : {1'b0, u_beta};
   assign mag_ob = b_rdata[31] ? 33'(-34'(b_rdata)) : {1'b0, b_rdata};
   assign chg_sum = {1'b0, chg_ff} + {1'b0, u_sq};
   assign tol2    = 62'({31'd0, tol_ff} * {31'd0, tol_ff});

   always_comb begin
      st_in    = st_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      grp_in   = grp_ff;
      pass_in  = pass_ff;
      sum_in   = sum_ff;
      chg_in   = chg_ff;
      any_in   = any_ff;
      flag_in  = flag_ff;
      out_v_in = out_v_ff;
      out_b_in = out_b_ff;
      out_l_in = out_l_ff;
      b_we     = 1'b0;
      b_waddr  = rd_addr;
      b_wdata  = rd_elem.value;
      uctl_i   = '0;

      if (out_v_ff && !rsp_stall) begin
         out_v_in = 1'b0;
      end

      unique case (st_ff)
         S_LOAD: begin
            if (e_we) begin
               count_in = count_ff + 1'b1;
            end
            if (accept && req_last_in) begin
               flag_in = 1'b0;
               grp_in  = '0;
               idx_in  = '0;
               sum_in  = '0;
               any_in  = 1'b0;
               if (e_we || count_ff != '0) begin
                  st_in = S_INITR;
               end
            end
         end
         S_INITR: begin
            if (idx_ff == count_ff) begin
               idx_in  = '0;
               chg_in  = '0;
               pass_in = '0;
               if (any_ff) begin
                  st_in = S_PASSR;
               end else begin
                  st_in = S_CHECK;
               end
            end else begin
               st_in = S_INITW;
            end
         end
         S_INITW: begin
            if (member) begin
               b_we   = 1'b1;
               sum_in = sum_ff + SumWidth'(mag_v);
               any_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            st_in  = S_INITR;
         end
         S_PASSR: begin
            if (idx_ff == count_ff) begin
               pass_in = pass_ff + 1'b1;
               st_in   = S_CHECK;
            end else begin
               st_in = S_PASSD;
            end
         end
         S_PASSD: begin
            if (member) begin
               uctl_i.start = 1'b1;
               st_in = S_UPD;
            end else begin
               idx_in = idx_ff + 1'b1;
               st_in  = S_PASSR;
            end
         end
         S_UPD: begin
            if (uctl_o.done) begin
               b_we    = 1'b1;
               b_wdata = u_beta;
               chg_in  = chg_sum[64] ? '1 : chg_sum[63:0];
               sum_in  = sum_ff + SumWidth'(mag_nb) - SumWidth'(mag_ob);
               idx_in  = idx_ff + 1'b1;
               st_in   = S_PASSR;
            end
         end
         S_CHECK: begin
            idx_in = '0;
            if (any_ff && chg_ff > {2'b00, tol2} && pass_ff < PW'(MAX_PASSES)) begin
               chg_in = '0;
               st_in  = S_PASSR;
            end else begin
               if (any_ff && chg_ff > {2'b00, tol2}) begin
                  flag_in = 1'b1;
               end
               sum_in = '0;
               any_in = 1'b0;
               if (grp_ff == GW'(MAX_GROUPS - 1)) begin
                  st_in = S_OUTR;
               end else begin
                  grp_in = grp_ff + 1'b1;
                  st_in  = S_INITR;
               end
            end
         end
         S_OUTR: begin
            if (!out_v_ff || !rsp_stall) begin
               st_in = S_OUTW;
            end
         end
         S_OUTW: begin
            out_v_in = 1'b1;
            out_b_in = b_rdata;
            out_l_in = (idx_ff + 1'b1 == count_ff);
            idx_in   = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == count_ff) begin
               count_in = '0;
               st_in    = S_LOAD;
            end else begin
               st_in = S_OUTR;
            end
         end
         default: st_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_LOAD;
         count_ff <= '0;
         out_v_ff <= 1'b0;
         flag_ff  <= 1'b0;
      end else begin
         st_ff    <= st_in;
         count_ff <= count_in;
         out_v_ff <= out_v_in;
         flag_ff  <= flag_in;
      end
      idx_ff   <= idx_in;
      grp_ff   <= grp_in;
      pass_ff  <= pass_in;
      sum_ff   <= sum_in;
      chg_ff   <= chg_in;
      any_ff   <= any_in;
      out_b_ff <= out_b_in;
      out_l_ff <= out_l_in;
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_beta_out       = out_b_ff;
   assign rsp_no_convergence = flag_ff;
   assign rsp_last_out       = out_l_ff;

endmodule

/* sv/elp_checker.sv */
`include "assert_macros.svh"

module elp_props
   import elp_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [ValueWidth-1:0] rsp_beta_out,
   input logic                         rsp_no_convergence,
   input logic                         rsp_last_out
);

   // A stalled result holds.
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_beta_out), "result changed under stall")
   // The block does not load while results are pending.
   `CHK_IMPL(a_no_load_out, clock, reset, rsp_valid, req_stall, "request taken while emitting")
   // The flag is the same over one run.
   `CHK_NEXT(a_flag_const, clock, reset, rsp_valid && !rsp_last_out, $stable(rsp_no_convergence), "flag changed in a run")

endmodule

bind exclusive_lasso_prox_engine_core elp_props u_elp_props (
   .clock (clock), .reset (reset), .req_valid (req_valid), .req_stall (req_stall),
   .rsp_valid (rsp_valid), .rsp_stall (rsp_stall), .rsp_beta_out (rsp_beta_out),
   .rsp_no_convergence (rsp_no_convergence), .rsp_last_out (rsp_last_out)
);
